[design/object_id_registry_assert.svh]
`ifndef OBJECT_ID_REGISTRY_ASSERT_SVH
`define OBJECT_ID_REGISTRY_ASSERT_SVH

// same-cycle implication, checked on clk, off during reset
`define OIR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define OIR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/oir_pkg.sv]
package oir_pkg;

	localparam int OIR_DEPTH    = 256;
	localparam int OIR_KEY_BITS = 32;

	localparam logic [1:0] FN_CHECKED   = 2'd0;
	localparam logic [1:0] FN_UNCHECKED = 2'd1;
	localparam logic [1:0] FN_LOOKUP    = 2'd2;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_INSERTED  = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic found;
		logic miss;
		logic append;
	} cmd_t;

	typedef struct packed {
		logic try_search;
		logic may_append;
		logic hit;
		logic scan_end;
	} stat_t;

endpackage

[design/object_id_registry.sv]
// Every beat enters the scan state; an unchecked insert goes straight on to append,
// a lookup or checked insert reads stored keys of its kind in turn, ends on a hit,
// and on a miss responds (lookup) or appends (checked insert). Throughput: one beat
// at a time, the next start taken the cycle after done; the key memory scans one
// stored key a cycle. Reset: arst_n clears both counts and the controller; stored
// keys are not cleared. The receiver cannot stall: done is a one-cycle strobe.
module object_id_registry
	import oir_pkg::*;
#(
	parameter int DEPTH    = OIR_DEPTH,
	parameter int KEY_BITS = OIR_KEY_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic        kind,
	input  logic [31:0] key_handle,
	output logic        done,
	output logic [7:0]  ident,
	output logic [1:0]  status
);

	`include "object_id_registry_assert.svh"

	cmd_t  cmd;
	stat_t stat;

	oir_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	oir_dp #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (func),
		.kind       (kind),
		.key_handle (key_handle),
		.stat       (stat),
		.ident      (ident),
		.status     (status)
	);

	`OIR_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted beat did not raise busy")
	`OIR_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "result strobe longer than one cycle")
	`OIR_ASSERT_NOW(a_zero_ident, done && (status == ST_NOT_FOUND || status == ST_FULL), ident == 8'd0, "nonzero ident on miss or full")
	`OIR_ASSERT_NOW(a_done_busy, done, busy, "result strobe while idle")

endmodule

[design/oir_ram.sv]
module oir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/oir_ctrl.sv]
module oir_ctrl
	import oir_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_APPEND = 4'b0100,
		S_RESP   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = stat.try_search;
				priority if (!stat.try_search) begin
					state_d = S_APPEND;
				end else if (stat.hit) begin
					cmd.found = 1'b1;
					state_d   = S_RESP;
				end else if (stat.scan_end) begin
					if (stat.may_append) begin
						state_d = S_APPEND;
					end else begin
						cmd.miss = 1'b1;
						state_d  = S_RESP;
					end
				end else begin
					state_d = S_SCAN;
				end
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				state_d    = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

[design/oir_dp.sv]
module oir_dp
	import oir_pkg::*;
#(
	parameter int DEPTH    = OIR_DEPTH,
	parameter int KEY_BITS = OIR_KEY_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [1:0]  func,
	input  logic        kind,
	input  logic [31:0] key_handle,
	output stat_t       stat,
	output logic [7:0]  ident,
	output logic [1:0]  status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [1:0]          func_q;
	logic                kind_q;
	logic [KEY_BITS-1:0] key_q;
	logic [CW-1:0]       rd_idx_q;
	logic [CW-1:0]       place_cnt_q;
	logic [CW-1:0]       trans_cnt_q;
	logic                pv_s1;
	logic [CW-1:0]       idx_s1;
	logic [7:0]          ident_q;
	status_t             status_q;

	logic [CW-1:0]       cnt;
	logic                more;
	logic                issue;
	logic                full;
	logic                wr_en;
	logic [KEY_BITS-1:0] rdata;
	logic [95:0]         key_wide;
	logic [CW+7:0]       found_wide;
	logic [CW+7:0]       cnt_wide;

	assign cnt        = kind_q ? trans_cnt_q : place_cnt_q;
	assign more       = (rd_idx_q != cnt);
	assign issue      = cmd.scan && more;
	assign full       = (cnt == CW'(DEPTH));
	assign wr_en      = cmd.append && !full;
	assign key_wide   = {64'd0, key_handle};
	assign found_wide = {8'd0, idx_s1};
	assign cnt_wide   = {8'd0, cnt};

	oir_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(2 * (2 ** AW))
	) u_keys (
		.clk   (clk),
		.we    (wr_en),
		.waddr ({kind_q, cnt[AW-1:0]}),
		.wdata (key_q),
		.re    (issue),
		.raddr ({kind_q, rd_idx_q[AW-1:0]}),
		.rdata (rdata)
	);

	always_comb begin
		stat.try_search = (func_q != FN_UNCHECKED);
		stat.may_append = (func_q == FN_CHECKED) || (func_q == FN_UNCHECKED);
		stat.hit        = pv_s1 && (rdata == key_q);
		stat.scan_end   = !more && !pv_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			kind_q <= kind;
			key_q  <= key_wide[KEY_BITS-1:0];
		end
		idx_s1 <= rd_idx_q;
		if (cmd.found) begin
			ident_q  <= found_wide[7:0];
			status_q <= ST_FOUND;
		end else if (cmd.miss) begin
			ident_q  <= 8'd0;
			status_q <= ST_NOT_FOUND;
		end else if (cmd.append) begin
			ident_q  <= full ? 8'd0 : cnt_wide[7:0];
			status_q <= full ? ST_FULL : ST_INSERTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			pv_s1       <= 1'b0;
			place_cnt_q <= '0;
			trans_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			pv_s1 <= issue && !cmd.load;
			if (wr_en) begin
				if (kind_q) begin
					trans_cnt_q <= trans_cnt_q + CW'(1);
				end else begin
					place_cnt_q <= place_cnt_q + CW'(1);
				end
			end
		end
	end

	assign ident  = ident_q;
	assign status = status_q;

endmodule
